/* rtl/tbcrg_pkg.sv */
package tbcrg_pkg;

    // Width of the signed working range used by the clipping arithmetic
    localparam int CW = 20;

    // Source tile width / height after dropping the pixel bits
    localparam int TILE_W = 13;

    // Clipped source column / row, which can pass 16 bits after a negative edge
    localparam int SRC_ADJ_W = 17;

    // Row count field wide enough for the largest destination map
    localparam int ROWS_MAX_W = 9;

    localparam int DST_W = 10;
    localparam int LEN_W = 6;
    localparam int MASK_W = 8;

    // One blit request
    typedef struct packed {
        logic signed [15:0] dest_x;
        logic signed [15:0] dest_y;
        logic        [15:0] src_x;
        logic        [15:0] src_y;
        logic signed [15:0] req_width;
        logic signed [15:0] req_height;
        logic        [15:0] src_width_pixels;
        logic        [15:0] src_height_pixels;
        logic               draw;
        logic        [2:0]  buffer_index;
    } t_in_item;

    // One row descriptor
    typedef struct packed {
        logic [31:0]       src_offset;
        logic [DST_W-1:0]  dst_offset;
        logic [LEN_W-1:0]  run_length;
        logic              op;
        logic              empty_res;
        logic              last;
        logic [MASK_W-1:0] dirty_mask;
    } t_out_item;

    // Clipped rectangle handed from the clip unit to the sequencer
    typedef struct packed {
        logic                  empty;
        logic [SRC_ADJ_W-1:0]  sx_adj;
        logic [SRC_ADJ_W-1:0]  sy_adj;
        logic [TILE_W-1:0]     srcw;
        logic [DST_W-1:0]      dst;
        logic [LEN_W-1:0]      len;
        logic [ROWS_MAX_W-1:0] rows;
    } t_clip;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLIP,
        ST_MUL,
        ST_ROWS,
        ST_EMPTY
    } t_state;

endpackage

/* rtl/tbcrg_clip.sv */
module tbcrg_clip
    import tbcrg_pkg::*;
#(
    parameter int MAP_COLS = 32,
    parameter int MAP_ROWS = 24
) (
    input  t_in_item i_req,
    output t_clip    o_clip
);

    localparam logic signed [CW-1:0] COLS_S = CW'(MAP_COLS);
    localparam logic signed [CW-1:0] ROWS_S = CW'(MAP_ROWS);

    logic [TILE_W-1:0]    srcw;
    logic [TILE_W-1:0]    srch;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] w_sel;
    logic signed [CW-1:0] h_sel;
    logic signed [CW-1:0] w_adj;
    logic signed [CW-1:0] h_adj;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] w_fin;
    logic signed [CW-1:0] h_fin;
    logic signed [CW-1:0] neg_dx;
    logic signed [CW-1:0] neg_dy;

    always_comb begin
        srcw = i_req.src_width_pixels[15:3];
        srch = i_req.src_height_pixels[15:3];
        dx   = CW'(i_req.dest_x);
        dy   = CW'(i_req.dest_y);
        neg_dx = -dx;
        neg_dy = -dy;

        // minus one selects the full source size
        w_sel = (i_req.req_width == -16'sd1) ?
                $signed({{(CW-TILE_W){1'b0}}, srcw}) : CW'(i_req.req_width);
        h_sel = (i_req.req_height == -16'sd1) ?
                $signed({{(CW-TILE_W){1'b0}}, srch}) : CW'(i_req.req_height);

        // negative destination edge pushes the source origin forward
        if (dx < 0) begin
            o_clip.sx_adj = {1'b0, i_req.src_x} + neg_dx[SRC_ADJ_W-1:0];
            w_adj         = w_sel + dx;
            x             = '0;
        end else begin
            o_clip.sx_adj = {1'b0, i_req.src_x};
            w_adj         = w_sel;
            x             = dx;
        end
        if (dy < 0) begin
            o_clip.sy_adj = {1'b0, i_req.src_y} + neg_dy[SRC_ADJ_W-1:0];
            h_adj         = h_sel + dy;
            y             = '0;
        end else begin
            o_clip.sy_adj = {1'b0, i_req.src_y};
            h_adj         = h_sel;
            y             = dy;
        end

        // far edges of the destination map
        w_fin = (x + w_adj > COLS_S) ? COLS_S - x : w_adj;
        h_fin = (y + h_adj > ROWS_S) ? ROWS_S - y : h_adj;

        o_clip.empty = (w_fin <= 0) || (h_fin <= 0);
        o_clip.srcw  = srcw;
        o_clip.dst   = x[DST_W-1:0] + y[DST_W-1:0] * DST_W'(MAP_COLS);
        o_clip.len   = w_fin[LEN_W-1:0];
        o_clip.rows  = h_fin[ROWS_MAX_W-1:0];
    end

endmodule

/* rtl/tilemap_blit_clip_row_generator_top.sv */
// Tile-rectangle blit row generator. Each accepted request is clipped to the
// MAP_COLS by MAP_ROWS destination map, then one row descriptor per clipped
// row is sent out (source offset, destination offset, run length, copy or
// clear), the final one flagged with last; an empty clip gives a single
// result with empty_res and last set. The buffer's bit is set in the dirty
// mask as the request is taken. A single 32-bit adder first forms the
// starting source offset by shift-and-add over the source width in tiles,
// then steps it by the source width for each row; an output stall holds the
// current row. Requests are not taken while one is in progress.
module tilemap_blit_clip_row_generator_top
    import tbcrg_pkg::*;
#(
    parameter int MAP_COLS    = 32,
    parameter int MAP_ROWS    = 24,
    parameter int NUM_BUFFERS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int ROW_W = $clog2(MAP_ROWS + 1);

    t_state             r_state, n_state;
    t_in_item           r_req, n_req;
    logic [MASK_W-1:0]  r_dirty, n_dirty;
    logic [31:0]        r_so, n_so;
    logic [31:0]        r_mcand, n_mcand;
    logic [TILE_W-1:0]  r_mplier, n_mplier;
    logic [TILE_W-1:0]  r_srcw, n_srcw;
    logic [DST_W-1:0]   r_dst, n_dst;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [ROW_W-1:0]   r_rows_left, n_rows_left;
    logic               r_op, n_op;

    t_clip              clip;
    logic [31:0]        addend;
    logic [31:0]        sum;

    tbcrg_clip #(
        .MAP_COLS (MAP_COLS),
        .MAP_ROWS (MAP_ROWS)
    ) u_clip (
        .i_req  (r_req),
        .o_clip (clip)
    );

    // shared adder: multiply steps, then per-row stride
    always_comb begin
        if (r_state == ST_MUL) begin
            addend = r_mplier[0] ? r_mcand : '0;
        end else begin
            addend = {{(32-TILE_W){1'b0}}, r_srcw};
        end
        sum = r_so + addend;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_dirty     = r_dirty;
        n_so        = r_so;
        n_mcand     = r_mcand;
        n_mplier    = r_mplier;
        n_srcw      = r_srcw;
        n_dst       = r_dst;
        n_len       = r_len;
        n_rows_left = r_rows_left;
        n_op        = r_op;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;

        o_out_data.src_offset = r_so;
        o_out_data.dst_offset = r_dst;
        o_out_data.run_length = r_len;
        o_out_data.op         = r_op;
        o_out_data.empty_res  = 1'b0;
        o_out_data.last       = (r_rows_left == ROW_W'(1));
        o_out_data.dirty_mask = r_dirty;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_req   = i_in_data;
                    n_state = ST_CLIP;
                    if (32'(i_in_data.buffer_index) < NUM_BUFFERS) begin
                        n_dirty = r_dirty | (MASK_W'(1) << i_in_data.buffer_index);
                    end
                end
            end
            ST_CLIP: begin
                n_so        = 32'(clip.sx_adj);
                n_mcand     = 32'(clip.sy_adj);
                n_mplier    = clip.srcw;
                n_srcw      = clip.srcw;
                n_dst       = clip.dst;
                n_len       = clip.len;
                n_rows_left = clip.rows[ROW_W-1:0];
                n_op        = r_req.draw;
                n_state     = clip.empty ? ST_EMPTY : ST_MUL;
            end
            ST_MUL: begin
                // shift-and-add of source row times source width
                if (r_mplier == '0) begin
                    n_state = ST_ROWS;
                end else begin
                    n_so     = sum;
                    n_mcand  = r_mcand << 1;
                    n_mplier = r_mplier >> 1;
                end
            end
            ST_ROWS: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_so        = sum;
                    n_dst       = r_dst + DST_W'(MAP_COLS);
                    n_rows_left = r_rows_left - ROW_W'(1);
                    if (r_rows_left == ROW_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_EMPTY: begin
                o_out_valid           = 1'b1;
                o_out_data.src_offset = '0;
                o_out_data.dst_offset = '0;
                o_out_data.run_length = '0;
                o_out_data.op         = 1'b0;
                o_out_data.empty_res  = 1'b1;
                o_out_data.last       = 1'b1;
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dirty <= '0;
        end else begin
            r_state <= n_state;
            r_dirty <= n_dirty;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_so        <= n_so;
        r_mcand     <= n_mcand;
        r_mplier    <= n_mplier;
        r_srcw      <= n_srcw;
        r_dst       <= n_dst;
        r_len       <= n_len;
        r_rows_left <= n_rows_left;
        r_op        <= n_op;
    end

    // checks
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("input ready while a result is pending");

    a_rows_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROWS) |-> (r_rows_left != '0))
        else $error("row state entered with no rows left");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.empty_res) |-> o_out_data.last)
        else $error("empty result not marked last");

    a_dirty_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((r_dirty & $past(r_dirty)) == $past(r_dirty)))
        else $error("dirty mask lost a bit");

endmodule

/* verif/tilemap_blit_clip_row_generator_top_test.sv */
`timescale 1ns / 1ps

module tilemap_blit_clip_row_generator_top_test;
    import tbcrg_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int MAP_COLS     = 32;
    localparam int MAP_ROWS     = 24;
    localparam int NUM_BUFFERS  = 8;
    localparam int FULL_SIZE    = -1;
    localparam int TILE_SHIFT   = 3;
    localparam int RANDOM_REQS  = 450;
    localparam int IDLE_PCT     = 36;
    localparam int STEADY_FROM  = 120;
    localparam int STEADY_TO    = 200;
    localparam int HOLD_AT      = 260;
    localparam int HOLD_CYCLES  = 400;
    localparam int PAUSE_AT     = 330;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_LIMIT  = 40;

    // One row of the directed table; want is only used when typed is set
    typedef struct {
        t_in_item  req;
        bit        typed;
        t_out_item want;
    } t_case;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    t_out_item         rows_due[$];
    t_out_item         plan_q[$];
    logic [MASK_W-1:0] dirty_bits = '0;
    t_case             dir_tab[$];
    int                reqs_taken = 0;
    int                err_count = 0;
    int                cycle_count = 0;
    int                hold_left = 0;
    bit                hold_done = 1'b0;

    tilemap_blit_clip_row_generator_top #(
        .MAP_COLS    (MAP_COLS),
        .MAP_ROWS    (MAP_ROWS),
        .NUM_BUFFERS (NUM_BUFFERS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Row planner: clip the request and list the row descriptors it gives
    // ------------------------------------------------------------------
    function automatic void plan_rows(input t_in_item r);
        int          dx, dy, w, h, x, y;
        int unsigned sx, sy, tiles_w, tiles_h;
        t_out_item   d;
        plan_q.delete();
        dx      = $signed(r.dest_x);
        dy      = $signed(r.dest_y);
        w       = $signed(r.req_width);
        h       = $signed(r.req_height);
        sx      = r.src_x;
        sy      = r.src_y;
        tiles_w = r.src_width_pixels >> TILE_SHIFT;
        tiles_h = r.src_height_pixels >> TILE_SHIFT;
        if (w == FULL_SIZE) w = int'(tiles_w);
        if (h == FULL_SIZE) h = int'(tiles_h);

        // negative edges push the source origin forward
        if (dx < 0) begin
            sx = sx + int'(-dx);
            w  = w + dx;
            x  = 0;
        end else begin
            x = dx;
        end
        if (x + w > MAP_COLS) w = MAP_COLS - x;
        if (dy < 0) begin
            sy = sy + int'(-dy);
            h  = h + dy;
            y  = 0;
        end else begin
            y = dy;
        end
        if (y + h > MAP_ROWS) h = MAP_ROWS - y;

        if (r.buffer_index < NUM_BUFFERS) dirty_bits = dirty_bits | MASK_W'(1 << r.buffer_index);

        d = '0;
        d.dirty_mask = dirty_bits;
        if (w <= 0 || h <= 0) begin
            d.empty_res = 1'b1;
            d.last      = 1'b1;
            plan_q.push_back(d);
        end else begin
            for (int row = 0; row < h; row++) begin
                d.src_offset = tiles_w * (sy + row) + sx;
                d.dst_offset = DST_W'(x + (y + row) * MAP_COLS);
                d.run_length = LEN_W'(w);
                d.op         = r.draw;
                d.last       = (row == h - 1);
                plan_q.push_back(d);
            end
        end
    endfunction

    function automatic t_in_item blit_req(input int dx, dy, sx, sy, w, h, pw, ph,
                                          input bit draw, input int bidx);
        t_in_item r;
        r.dest_x            = 16'(dx);
        r.dest_y            = 16'(dy);
        r.src_x             = 16'(sx);
        r.src_y             = 16'(sy);
        r.req_width         = 16'(w);
        r.req_height        = 16'(h);
        r.src_width_pixels  = 16'(pw);
        r.src_height_pixels = 16'(ph);
        r.draw              = draw;
        r.buffer_index      = 3'(bidx);
        return r;
    endfunction

    function automatic t_out_item empty_row(input logic [MASK_W-1:0] mask);
        t_out_item d;
        d            = '0;
        d.empty_res  = 1'b1;
        d.last       = 1'b1;
        d.dirty_mask = mask;
        return d;
    endfunction

    function automatic logic [15:0] corner_word();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h7FFF;
            3: return 16'h8000;
            4: return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly rectangles near the map, some raw noise, some corner mixes
    function automatic t_in_item rand_req();
        t_in_item     r;
        logic [159:0] noise;
        int           pick;
        pick = $urandom_range(99);
        if (pick < 65) begin
            r.dest_x     = 16'(int'($urandom_range(44)) - 8);
            r.dest_y     = 16'(int'($urandom_range(34)) - 6);
            r.req_width  = ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom_range(1, 34));
            r.req_height = ($urandom_range(7) == 0) ? 16'hFFFF :
                           16'($urandom_range(1, ($urandom_range(3) == 0) ? 26 : 8));
            r.src_x      = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(255));
            r.src_y      = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(255));
            r.src_width_pixels  = $urandom_range(3) ? 16'($urandom_range(8, 2048)) :
                                  16'($urandom);
            r.src_height_pixels = $urandom_range(3) ? 16'($urandom_range(8, 2048)) :
                                  16'($urandom);
            r.draw         = 1'($urandom);
            r.buffer_index = 3'($urandom);
        end else if (pick < 85) begin
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
            r     = noise[$bits(t_in_item)-1:0];
        end else begin
            r.dest_x            = corner_word();
            r.dest_y            = corner_word();
            r.src_x             = corner_word();
            r.src_y             = corner_word();
            r.req_width         = corner_word();
            r.req_height        = corner_word();
            r.src_width_pixels  = corner_word();
            r.src_height_pixels = corner_word();
            r.draw              = 1'($urandom);
            r.buffer_index      = 3'($urandom);
        end
        return r;
    endfunction

    function automatic bit steady_phase();
        return reqs_taken >= STEADY_FROM && reqs_taken < STEADY_TO;
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < PRINT_LIMIT) $display("MISMATCH at %0t: %s", $time, msg);
        err_count++;
    endtask

    // Offer one request, optionally after an idle gap, and log its rows once taken
    task automatic send_request(input t_in_item r, input bit typed, input t_out_item want);
        int gap;
        gap = 0;
        if (!steady_phase() && $urandom_range(99) < IDLE_PCT) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do @(posedge i_clk); while (!o_in_ready);
        plan_rows(r);
        if (typed) begin
            rows_due.push_back(want);
        end else begin
            foreach (plan_q[k]) rows_due.push_back(plan_q[k]);
        end
        reqs_taken <= reqs_taken + 1;
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    initial begin
        // empty clips, one per buffer so the mask reads off directly
        dir_tab.push_back('{blit_req(32, 0, 0, 0, 1, 1, 64, 64, 1, 0), 1'b1, empty_row(8'h01)});
        dir_tab.push_back('{blit_req(0, 24, 0, 0, 1, 1, 64, 64, 1, 1), 1'b1, empty_row(8'h03)});
        dir_tab.push_back('{blit_req(0, 0, 0, 0, -2, 1, 64, 64, 1, 2), 1'b1, empty_row(8'h07)});
        dir_tab.push_back('{blit_req(0, 0, 0, 0, 4, 0, 64, 64, 0, 3), 1'b1, empty_row(8'h0F)});
        dir_tab.push_back('{blit_req(-32768, 0, 0, 0, 32767, 1, 64, 64, 1, 4), 1'b1,
                            empty_row(8'h1F)});
        dir_tab.push_back('{blit_req(0, 0, 0, 0, -1, -1, 7, 7, 1, 5), 1'b1, empty_row(8'h3F)});
        // single tile at the origin, then two more empty clips
        dir_tab.push_back('{blit_req(0, 0, 0, 0, 1, 1, 8, 8, 1, 6), 1'b1,
                            t_out_item'{32'd0, 10'd0, 6'd1, 1'b1, 1'b0, 1'b1, 8'h7F}});
        dir_tab.push_back('{blit_req(32767, 32767, 0, 0, -32768, 1, 64, 64, 1, 7), 1'b1,
                            empty_row(8'hFF)});
        dir_tab.push_back('{blit_req(-3, 0, 0, 0, 3, 2, 64, 64, 1, 0), 1'b1, empty_row(8'hFF)});
        // full-map and clipped rectangles, some clipped away to empty
        dir_tab.push_back('{blit_req(0, 0, 0, 0, -1, -1, 256, 192, 1, 0), 1'b0, '0});
        dir_tab.push_back('{blit_req(0, 0, 65535, 65535, 32767, 32767, 65535, 65535, 0, 1),
                            1'b0, '0});
        dir_tab.push_back('{blit_req(-5, -3, 2, 1, -1, -1, 320, 240, 0, 5), 1'b0, '0});
        dir_tab.push_back('{blit_req(31, 23, 100, 50, 10, 10, 2048, 2048, 1, 7), 1'b0, '0});
        dir_tab.push_back('{blit_req(-1, -1, 65535, 65535, 3, 2, 65535, 65535, 1, 6), 1'b0, '0});
        dir_tab.push_back('{blit_req(-32768, -32768, 0, 0, -1, -1, 65535, 65535, 1, 3), 1'b1,
                            empty_row(8'hFF)});
        dir_tab.push_back('{blit_req(0, 20, 0, 0, -1, 8, 80, 80, 1, 1), 1'b0, '0});
        dir_tab.push_back('{blit_req(30, 0, 7, 9, 5, 1, 512, 512, 0, 2), 1'b0, '0});
        dir_tab.push_back('{blit_req(0, 0, 0, 0, 4, -32768, 64, 64, 1, 2), 1'b1,
                            empty_row(8'hFF)});
        dir_tab.push_back('{blit_req(-32767, 0, 0, 0, 32767, 1, 64, 64, 0, 4), 1'b1,
                            empty_row(8'hFF)});
        dir_tab.push_back('{blit_req(5, 5, 0, 0, 1, 24, 65528, 8, 0, 3), 1'b0, '0});

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k]) send_request(dir_tab[k].req, dir_tab[k].typed, dir_tab[k].want);

        for (int n = 0; n < RANDOM_REQS; n++) begin
            // let the block drain completely once
            if (dir_tab.size() + n == PAUSE_AT) begin
                i_in_valid <= 1'b0;
                while (rows_due.size() != 0) @(posedge i_clk);
            end
            send_request(rand_req(), 1'b0, '0);
        end

        i_in_valid <= 1'b0;
        while (rows_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("** tilemap_blit_clip_row_generator_top: PASSED **");
        end else begin
            $display("** tilemap_blit_clip_row_generator_top: FAILED **");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random backpressure plus one long hold-off
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!hold_done && reqs_taken == HOLD_AT) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (steady_phase()) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Compare each row descriptor transaction with the oldest expected one
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (rows_due.size() == 0) begin
                report_mismatch($sformatf("unexpected row descriptor %p", o_out_data));
            end else begin
                want = rows_due.pop_front();
                if (o_out_data.src_offset !== want.src_offset)
                    report_mismatch($sformatf("src_offset %0h, expected %0h",
                                              o_out_data.src_offset, want.src_offset));
                if (o_out_data.dst_offset !== want.dst_offset)
                    report_mismatch($sformatf("dst_offset %0d, expected %0d",
                                              o_out_data.dst_offset, want.dst_offset));
                if (o_out_data.run_length !== want.run_length)
                    report_mismatch($sformatf("run_length %0d, expected %0d",
                                              o_out_data.run_length, want.run_length));
                if (o_out_data.op !== want.op)
                    report_mismatch($sformatf("op %b, expected %b", o_out_data.op, want.op));
                if (o_out_data.empty_res !== want.empty_res)
                    report_mismatch($sformatf("empty_res %b, expected %b",
                                              o_out_data.empty_res, want.empty_res));
                if (o_out_data.last !== want.last)
                    report_mismatch($sformatf("last %b, expected %b",
                                              o_out_data.last, want.last));
                if (o_out_data.dirty_mask !== want.dirty_mask)
                    report_mismatch($sformatf("dirty_mask %h, expected %h",
                                              o_out_data.dirty_mask, want.dirty_mask));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles, %0d rows outstanding", cycle_count,
                     rows_due.size());
            $display("** tilemap_blit_clip_row_generator_top: FAILED **");
            $finish;
        end
    end

endmodule
